FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/hrfs_pkg.sv
package hrfs_pkg;

   localparam int SectorCount = 8;
   localparam int SecIdxW     = 4;
   localparam int SectorW     = 3;
   localparam logic [SecIdxW-1:0] NoSector = 4'hF;

   localparam logic [31:0] AxiBase  = 32'h0800_0000;
   localparam logic [31:0] ItcmBase = 32'h0020_0000;

   localparam logic [31:0] SectorStart [SectorCount] = '{
      32'h0800_0000, 32'h0800_4000, 32'h0800_8000, 32'h0800_C000,
      32'h0801_0000, 32'h0802_0000, 32'h0804_0000, 32'h0806_0000
   };

   localparam logic OP_HEADER  = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   localparam logic [7:0] REC_DATA       = 8'd0;
   localparam logic [7:0] REC_EOF        = 8'd1;
   localparam logic [7:0] REC_EXT_SEG    = 8'd2;
   localparam logic [7:0] REC_START_SEG  = 8'd3;
   localparam logic [7:0] REC_EXT_LIN    = 8'd4;
   localparam logic [7:0] REC_START_LIN  = 8'd5;

   localparam int QDepth = 4;
   localparam int QPtrW  = 2;
   localparam int QCntW  = 3;

   typedef enum logic [2:0] {
      CMD_ERASE = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_LOCK  = 3'd2,
      CMD_FAULT = 3'd3,
      CMD_RANGE = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type     kind;
      logic [31:0] addr;
      logic [7:0]  data;
   } qent_type;

   function automatic logic [SecIdxW-1:0] find_sector(input logic [31:0] addr);
      logic [SecIdxW-1:0] sec;
      sec = NoSector;
      for (int i = 0; i < SectorCount; i++) begin
         if (addr >= SectorStart[i]) begin
            sec = SecIdxW'(i);
         end
      end
      return sec;
   endfunction

endpackage

FILE: rtl/hrfs_front.sv
module hrfs_front import hrfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] flash_size_kb,
   input  logic        accept,
   input  logic        opcode,
   input  logic [7:0]  record_type,
   input  logic [15:0] load_offset,
   input  logic [7:0]  byte_count,
   input  logic [7:0]  data_byte,
   output logic        push,
   output qent_type    push_entry
);

   logic [15:0] upper_ff, upper_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] start_ff, start_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  left_ff, left_in;
   logic        skip_ff, skip_in;
   logic        halted_ff, halted_in;

   logic [31:0] hdr_addr;
   logic [31:0] pay_addr;
   logic [32:0] win_span;
   logic [32:0] axi_end;
   logic [32:0] itcm_end;
   logic        in_axi;
   logic        in_itcm;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= '0;
         type_ff   <= '0;
         start_ff  <= '0;
         index_ff  <= '0;
         left_ff   <= '0;
         skip_ff   <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         upper_ff  <= upper_in;
         type_ff   <= type_in;
         start_ff  <= start_in;
         index_ff  <= index_in;
         left_ff   <= left_in;
         skip_ff   <= skip_in;
         halted_ff <= halted_in;
      end
   end

   always_comb begin
      hdr_addr = {upper_ff, load_offset};
      pay_addr = start_ff + {24'b0, index_ff};
      win_span = {11'b0, flash_size_kb, 10'b0};
      axi_end  = {1'b0, AxiBase} + win_span;
      itcm_end = {1'b0, ItcmBase} + win_span;
      in_axi   = (hdr_addr >= AxiBase) && ({1'b0, hdr_addr} < axi_end);
      in_itcm  = (hdr_addr >= ItcmBase) && ({1'b0, hdr_addr} < itcm_end);

      upper_in   = upper_ff;
      type_in    = type_ff;
      start_in   = start_ff;
      index_in   = index_ff;
      left_in    = left_ff;
      skip_in    = skip_ff;
      halted_in  = halted_ff;
      push       = 1'b0;
      push_entry = '{kind: CMD_WRITE, addr: '0, data: '0};

      if (accept && !halted_ff) begin
         if (opcode == OP_HEADER) begin
            type_in  = record_type;
            left_in  = byte_count;
            index_in = '0;
            skip_in  = 1'b0;
            unique case (record_type)
               REC_DATA: begin
                  if (in_axi) begin
                     start_in = hdr_addr;
                  end else if (in_itcm) begin
                     start_in = hdr_addr - ItcmBase + AxiBase;
                  end else begin
                     skip_in    = 1'b1;
                     push       = 1'b1;
                     push_entry = '{kind: CMD_RANGE, addr: hdr_addr, data: '0};
                  end
               end
               REC_EOF: begin
                  halted_in  = 1'b1;
                  push       = 1'b1;
                  push_entry = '{kind: CMD_LOCK, addr: '0, data: '0};
               end
               REC_EXT_SEG, REC_START_SEG, REC_EXT_LIN, REC_START_LIN: begin
               end
               default: begin
                  halted_in  = 1'b1;
                  push       = 1'b1;
                  push_entry = '{kind: CMD_FAULT, addr: '0, data: '0};
               end
            endcase
         end else if (left_ff != '0) begin
            left_in  = left_ff - 8'd1;
            index_in = index_ff + 8'd1;
            if (type_ff == REC_DATA) begin
               if (!skip_ff) begin
                  push       = 1'b1;
                  push_entry = '{kind: CMD_WRITE, addr: pay_addr, data: data_byte};
               end
            end else if (type_ff == REC_EXT_LIN) begin
               if (index_ff == 8'd0) begin
                  upper_in = {data_byte, upper_ff[7:0]};
               end else if (index_ff == 8'd1) begin
                  upper_in = {upper_ff[15:8], data_byte};
               end
            end
         end
      end
   end

endmodule

FILE: rtl/hrfs_queue.sv
module hrfs_queue import hrfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type push_entry,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output qent_type head
);

   qent_type           entries_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      full      = (count_ff == QCntW'(QDepth));
      empty     = (count_ff == '0);
      head      = entries_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCntW'(push) - QCntW'(pop);
   end

endmodule

FILE: rtl/hrfs_back.sv
module hrfs_back import hrfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  qent_type           head,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [2:0]         rsp_command,
   output logic [31:0]        rsp_flash_address,
   output logic [7:0]         rsp_write_data,
   output logic [SectorW-1:0] rsp_sector_number,
   output logic               rsp_last
);

   logic               valid_ff, valid_in;
   cmd_type            cmd_ff, cmd_in;
   logic [31:0]        addr_ff, addr_in;
   logic [7:0]         data_ff, data_in;
   logic [SectorW-1:0] sector_ff, sector_in;
   logic               last_ff, last_in;
   logic [SecIdxW-1:0] erased_ff, erased_in;

   logic [SecIdxW-1:0] sec;
   logic               need_erase;
   logic               load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         erased_ff <= NoSector;
      end else begin
         valid_ff  <= valid_in;
         erased_ff <= erased_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      data_ff   <= data_in;
      sector_ff <= sector_in;
      last_ff   <= last_in;
   end

   always_comb begin
      sec        = find_sector(head.addr);
      need_erase = head_valid && (head.kind == CMD_WRITE)
                   && (sec != NoSector) && (sec != erased_ff);
      load       = !valid_ff || !rsp_stall;

      valid_in  = valid_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      sector_in = sector_ff;
      last_in   = last_ff;
      erased_in = erased_ff;
      pop       = 1'b0;

      if (load) begin
         valid_in = head_valid;
         if (need_erase) begin
            cmd_in    = CMD_ERASE;
            addr_in   = head.addr;
            data_in   = '0;
            sector_in = sec[SectorW-1:0];
            last_in   = 1'b0;
            erased_in = sec;
         end else if (head_valid) begin
            cmd_in    = head.kind;
            addr_in   = head.addr;
            data_in   = head.data;
            sector_in = '0;
            last_in   = 1'b1;
            pop       = 1'b1;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_command       = cmd_ff;
   assign rsp_flash_address = addr_ff;
   assign rsp_write_data    = data_ff;
   assign rsp_sector_number = sector_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: rtl/hex_record_flash_sequencer.sv
// Flash command sequencer for pre-verified Intel HEX records. A header item
// (type, load offset, byte count) is followed by one item per payload byte.
// The front end takes one item per clock into a 4-entry command queue; the
// back end issues one command per clock from its output register while
// rsp_stall is low. A payload byte that opens a new sector gives an erase
// followed by a write, so it holds the single result register for both
// commands. Input stalls only when the queue is full. End of file or an
// unknown record type halts the block until reset; later items are taken
// and dropped. csr_ready is always high; flash_size_kb should only be
// changed while no transfer is in flight.
`include "assert_macros.svh"

module hex_record_flash_sequencer import hrfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [7:0]         req_record_type,
   input  logic [15:0]        req_load_offset,
   input  logic [7:0]         req_byte_count,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_command,
   output logic [31:0]        rsp_flash_address,
   output logic [7:0]         rsp_write_data,
   output logic [SectorW-1:0] rsp_sector_number,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [11:0]        csr_flash_size_kb
);

   logic [11:0] size_kb_ff, size_kb_in;
   logic        req_accept;
   logic        q_push;
   qent_type    q_push_entry;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   qent_type    q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_kb_ff <= 12'd512;
      end else begin
         size_kb_ff <= size_kb_in;
      end
   end

   always_comb begin
      csr_ready  = 1'b1;
      size_kb_in = (csr_valid && csr_ready) ? csr_flash_size_kb : size_kb_ff;
      req_stall  = q_full;
      req_accept = req_valid && !req_stall;
   end

   hrfs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .flash_size_kb (size_kb_ff),
      .accept        (req_accept),
      .opcode        (req_opcode),
      .record_type   (req_record_type),
      .load_offset   (req_load_offset),
      .byte_count    (req_byte_count),
      .data_byte     (req_data_byte),
      .push          (q_push),
      .push_entry    (q_push_entry)
   );

   hrfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   hrfs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (!q_empty),
      .head              (q_head),
      .pop               (q_pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_command       (rsp_command),
      .rsp_flash_address (rsp_flash_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_sector_number (rsp_sector_number),
      .rsp_last          (rsp_last)
   );

   `ASSERT_IMPLIES(a_push_room, clock, reset, q_push, !q_full, "push into full queue")
   `ASSERT_IMPLIES(a_pop_data, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `ASSERT_NEXT(a_erase_then_write, clock, reset,
      rsp_valid && !rsp_stall && rsp_command == CMD_ERASE,
      rsp_valid && rsp_command == CMD_WRITE && rsp_last, "erase not followed by write")

endmodule
